/* rtl/core/frs_pkg.sv */
// ----------------------------------------------------------------------------
// frs_pkg: shared types and constants of the frame reorder sorter
// Frame widths, store depth, the entry carried along the cell chain and the
// control word that the sequencer broadcasts to every cell.
// ----------------------------------------------------------------------------
package frs_pkg;

  localparam int MAX_FRAMES    = 32;
  localparam int PAYLOAD_BYTES = 3;
  localparam int SEQ_W         = 8;
  localparam int PAY_W         = 24;

  // Payload bits kept from the input field.
  localparam logic [PAY_W-1:0] PAY_MASK =
    (PAYLOAD_BYTES >= 3) ? {PAY_W{1'b1}} : PAY_W'((64'd1 << (8 * PAYLOAD_BYTES)) - 64'd1);

  typedef struct packed {
    logic             valid;
    logic [SEQ_W-1:0] seq;
    logic [PAY_W-1:0] pay;
  } entry_t;

  typedef struct packed {
    logic ins;    // insert the broadcast frame
    logic shift;  // move every entry one cell toward the head
    logic clr;    // empty the chain
  } cell_ctl_t;

endpackage

/* rtl/core/frs_cell.sv */
// ----------------------------------------------------------------------------
// frs_cell: one insertion cell of the sorting chain
// Holds one frame. On insert it keeps its entry, takes the new frame, or takes
// its upstream neighbor's entry; on drain it takes its downstream neighbor's.
// ----------------------------------------------------------------------------
module frs_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  frs_pkg::cell_ctl_t ctl,
  input  frs_pkg::entry_t   frm,
  input  frs_pkg::entry_t   prev_ent,
  input  logic              prev_take,
  input  frs_pkg::entry_t   next_ent,
  output frs_pkg::entry_t   ent,
  output logic              take
);

  logic                      valid_r, valid_nxt;
  logic [frs_pkg::SEQ_W-1:0] seq_r, seq_nxt;
  logic [frs_pkg::PAY_W-1:0] pay_r, pay_nxt;

  assign ent.valid = valid_r;
  assign ent.seq   = seq_r;
  assign ent.pay   = pay_r;

  // This cell gives way when it is empty or holds a strictly larger number,
  // so equal numbers stay ahead of the new frame.
  assign take = !valid_r || (seq_r > frm.seq);

  always_comb begin
    valid_nxt = valid_r;
    seq_nxt   = seq_r;
    pay_nxt   = pay_r;
    priority if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins) begin
      if (prev_take) begin
        valid_nxt = prev_ent.valid;
        seq_nxt   = prev_ent.seq;
        pay_nxt   = prev_ent.pay;
      end else if (take) begin
        valid_nxt = frm.valid;
        seq_nxt   = frm.seq;
        pay_nxt   = frm.pay;
      end
    end else if (ctl.shift) begin
      valid_nxt = next_ent.valid;
      seq_nxt   = next_ent.seq;
      pay_nxt   = next_ent.pay;
    end else begin
      // Idle cycles hold the entry.
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    pay_r <= pay_nxt;
  end

endmodule

/* rtl/core/frame_reorder_sorter.sv */
// ----------------------------------------------------------------------------
// frame_reorder_sorter: sequence-number frame sort
// Collects a batch of frames into a chain of insertion cells kept in
// ascending sequence order and emits the sorted batch on the batch end frame.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    in_sequence_number, in_payload,
//                                            in_batch_end
//   out_     output     out_valid/out_ready  out_sequence, out_payload,
//                                            out_overload, out_last
//
// A frame beat slots into its sorted place in the chain as soon as it is
// taken. After the batch end beat the chain drains through cell 0, one result
// beat per cycle while out_ready is high.
// An overloaded batch gives one result beat instead. Input waits while results
// are pending, and a stall on out_ready holds the chain and the result beat.
// Reset (rst_n low at a clock edge) empties the chain and clears the overflow.
//
module frame_reorder_sorter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [frs_pkg::SEQ_W-1:0] in_sequence_number,
  input  logic [frs_pkg::PAY_W-1:0] in_payload,
  input  logic                      in_batch_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [frs_pkg::SEQ_W-1:0] out_sequence,
  output logic [frs_pkg::PAY_W-1:0] out_payload,
  output logic                      out_overload,
  output logic                      out_last
);

  // Sequencer states: collecting frames, draining the sorted chain, and
  // presenting the single overload beat.
  typedef enum logic [2:0] {
    S_FILL  = 3'b001,
    S_DRAIN = 3'b010,
    S_OVLD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   ovf_r, ovf_nxt;

  frs_pkg::entry_t    ents [frs_pkg::MAX_FRAMES];
  logic               takes [frs_pkg::MAX_FRAMES];
  frs_pkg::entry_t    frm;
  frs_pkg::cell_ctl_t ctl;

  logic in_acc, out_acc, full;

  // The chain is full once its tail cell holds a frame.
  assign full     = ents[frs_pkg::MAX_FRAMES-1].valid;
  assign in_ready = (state_r == S_FILL);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  assign frm.valid = 1'b1;
  assign frm.seq   = in_sequence_number;
  assign frm.pay   = in_payload & frs_pkg::PAY_MASK;

  // Frames that arrive while the chain is full are dropped.
  assign ctl.ins   = in_acc && !full;
  assign ctl.shift = (state_r == S_DRAIN) && out_acc;
  assign ctl.clr   = (state_r == S_OVLD) && out_acc;

  // Row of cells: cell 0 is the head, it holds the smallest number.
  for (genvar i = 0; i < frs_pkg::MAX_FRAMES; i++) begin : g_cell
    frs_pkg::entry_t prev_ent, next_ent;
    logic            prev_take;

    if (i == 0) begin : g_head
      assign prev_ent  = '0;
      assign prev_take = 1'b0;
    end else begin : g_mid
      assign prev_ent  = ents[i-1];
      assign prev_take = takes[i-1];
    end

    if (i == frs_pkg::MAX_FRAMES - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_body
      assign next_ent = ents[i+1];
    end

    frs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .frm       (frm),
      .prev_ent  (prev_ent),
      .prev_take (prev_take),
      .next_ent  (next_ent),
      .ent       (ents[i]),
      .take      (takes[i])
    );
  end

  // Drain result beats come straight from the head cell.
  always_comb begin
    out_valid    = 1'b0;
    out_sequence = '0;
    out_payload  = '0;
    out_overload = 1'b0;
    out_last     = 1'b0;
    unique case (state_r)
      S_FILL: begin
      end
      S_DRAIN: begin
        out_valid    = 1'b1;
        out_sequence = ents[0].seq;
        out_payload  = ents[0].pay;
        out_last     = !ents[1].valid;
      end
      S_OVLD: begin
        out_valid    = 1'b1;
        out_overload = 1'b1;
        out_last     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      S_FILL: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end
          if (in_batch_end) begin
            state_nxt = (ovf_r || full) ? S_OVLD : S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (out_acc && out_last) begin
          state_nxt = S_FILL;
        end
      end
      S_OVLD: begin
        if (out_acc) begin
          state_nxt = S_FILL;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // The head of the chain stays sorted: the first two held frames never step downward.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (ents[0].valid && ents[1].valid) |-> (ents[0].seq <= ents[1].seq))
    else $error("cell chain out of order");

  // A drain beat always has a frame in the head cell.
  a_drain_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> ents[0].valid)
    else $error("drain with empty head cell");

  // The final beat of a batch leaves the chain empty and the overflow clear.
  a_batch_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last) |=> (!ents[0].valid && !ovf_r && in_ready))
    else $error("chain not empty after batch");

  // Input and output are never open in the same cycle.
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input open while results pending");

endmodule

/* bench/tb_frame_reorder_sorter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_reorder_sorter: self-checking bench for the frame reorder sorter
// Feeds batches of frames in scrambled sequence order and predicts the sorted
// batch, with ties kept in arrival order and the single overload beat on
// oversized batches. Both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module tb_frame_reorder_sorter;

  typedef logic [frs_pkg::SEQ_W-1:0] seq_t;
  typedef logic [frs_pkg::PAY_W-1:0] pay_t;

  // One beat on the result channel, as the predictor expects to see it.
  typedef struct {
    seq_t seq;
    pay_t pay;
    logic overload;
    logic last;
  } sorted_beat_t;

  // Scoreboard: keeps its own sorted copy of the batch being collected and
  // turns it into the expected result beats when the batch end frame is taken.
  class frame_sort_scoreboard;
    seq_t         held_seq [frs_pkg::MAX_FRAMES];
    pay_t         held_pay [frs_pkg::MAX_FRAMES];
    int unsigned  held_cnt;
    bit           batch_dropped;
    sorted_beat_t sorted_beats_q [$];
    int unsigned  mismatches;

    function new();
      held_cnt      = 0;
      batch_dropped = 0;
      mismatches    = 0;
    endfunction

    function int unsigned pending();
      return sorted_beats_q.size();
    endfunction

    // Called for every frame beat the block has taken.
    function void file_frame(seq_t seq, pay_t pay, logic batch_end);
      int unsigned  pos;
      sorted_beat_t beat;
      if (held_cnt < frs_pkg::MAX_FRAMES) begin
        // Insertion step: larger numbers move up, equal ones stay ahead.
        pos = held_cnt;
        while (pos > 0 && held_seq[pos-1] > seq) begin
          held_seq[pos] = held_seq[pos-1];
          held_pay[pos] = held_pay[pos-1];
          pos--;
        end
        held_seq[pos] = seq;
        held_pay[pos] = pay & frs_pkg::PAY_MASK;
        held_cnt++;
      end else begin
        batch_dropped = 1;
      end
      if (!batch_end) return;
      if (batch_dropped) begin
        beat.seq      = '0;
        beat.pay      = '0;
        beat.overload = 1'b1;
        beat.last     = 1'b1;
        sorted_beats_q.push_back(beat);
      end else begin
        for (int unsigned i = 0; i < held_cnt; i++) begin
          beat.seq      = held_seq[i];
          beat.pay      = held_pay[i];
          beat.overload = 1'b0;
          beat.last     = (i + 1 == held_cnt);
          sorted_beats_q.push_back(beat);
        end
      end
      held_cnt      = 0;
      batch_dropped = 0;
    endfunction

    // Called for every result beat the block has handed over.
    function void check_beat(seq_t seq, pay_t pay, logic overload, logic last);
      sorted_beat_t want;
      if (sorted_beats_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result beat seq=%0h pay=%0h ovl=%0b last=%0b",
                   $realtime, seq, pay, overload, last);
        return;
      end
      want = sorted_beats_q.pop_front();
      if (seq !== want.seq || pay !== want.pay || overload !== want.overload ||
          last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch exp seq=%0h pay=%0h ovl=%0b last=%0b",
                   $realtime, want.seq, want.pay, want.overload, want.last);
          $display("%0t:                 got seq=%0h pay=%0h ovl=%0b last=%0b",
                   $realtime, seq, pay, overload, last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n              = 1'b0;
  logic in_valid           = 1'b0;
  logic in_ready;
  seq_t in_sequence_number = '0;
  pay_t in_payload         = '0;
  logic in_batch_end       = 1'b0;
  logic out_valid;
  logic out_ready          = 1'b0;
  seq_t out_sequence;
  pay_t out_payload;
  logic out_overload;
  logic out_last;

  frame_sort_scoreboard sb;

  // Sender pacing: frames go out in bursts, and a gap may open between bursts.
  int unsigned burst_left  = 0;
  bit          gaps_on     = 1'b1;
  int unsigned frames_sent = 0;

  // Receiver pacing: a stall mode is held for a random stretch of cycles.
  int unsigned stall_mode   = 0;
  int unsigned stall_left   = 0;
  int unsigned stall_period = 1;
  int unsigned stall_phase  = 0;

  frame_reorder_sorter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sequence_number (in_sequence_number),
    .in_payload         (in_payload),
    .in_batch_end       (in_batch_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sequence       (out_sequence),
    .out_payload        (out_payload),
    .out_overload       (out_overload),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver. Three stall modes are picked at random: always ready, a coin toss
  // per cycle, and ready for a single cycle at the start of each random period.
  // The always-ready stretches make sure the chain also drains at full rate.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode   = $urandom_range(2, 0);
      stall_left   = $urandom_range(80, 16);
      stall_period = $urandom_range(8, 2);
      stall_phase  = 0;
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(1, 0) != 0);
      end
      default: begin
        out_ready   <= (stall_phase == 0);
        stall_phase  = (stall_phase + 1) % stall_period;
      end
    endcase
  end

  // Result monitor. Sampled at the edge, so the values seen are the ones the
  // handshake completed with.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_beat(out_sequence, out_payload, out_overload, out_last);
  end

  // Drops valid and lets the given number of cycles pass.
  task automatic idle_cycles(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Presents one frame and holds it until the block takes it. Valid is left
  // high afterwards so that back-to-back frames need no dead cycle; the next
  // call or an idle lowers it.
  task automatic push_frame(input seq_t seq, input pay_t pay, input logic batch_end);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(10, 1);
      gap        = gaps_on ? $urandom_range(5, 0) : 0;
      if (gap != 0)
        idle_cycles(gap);
    end
    burst_left--;
    in_valid           <= 1'b1;
    in_sequence_number <= seq;
    in_payload         <= pay;
    in_batch_end       <= batch_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.file_frame(seq, pay, batch_end);
    frames_sent++;
  endtask

  // Holds the sender off until every predicted result beat has come back.
  task automatic drain_results();
    idle_cycles(1);
    while (sb.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // One batch of n frames with random content. The numbering style varies so
  // that fully scrambled, tie-heavy, presorted and reversed batches all occur;
  // sequence numbers wrap freely, which also puts 0 and 255 side by side.
  task automatic run_batch(input int unsigned n);
    int unsigned style;
    seq_t        base;
    seq_t        seq;
    style   = $urandom_range(3, 0);
    base    = seq_t'($urandom_range(255, 0));
    gaps_on = ($urandom_range(3, 0) != 0);
    for (int unsigned i = 0; i < n; i++) begin
      case (style)
        0:       seq = seq_t'($urandom_range(255, 0));
        1:       seq = base + seq_t'($urandom_range(3, 0));
        2:       seq = base + seq_t'(i);
        default: seq = base - seq_t'(i);
      endcase
      push_frame(seq, pay_t'($urandom()), i == n - 1);
    end
  endtask

  initial begin
    int unsigned pick;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Two one-frame batches at the extremes of both fields.
    push_frame(8'hFF, 24'hFFFFFF, 1'b1);
    push_frame(8'h00, 24'h000000, 1'b1);

    // A scrambled batch with ties at 0, 128 and 255. Payloads differ so that
    // any swap among equal sequence numbers shows up in the compare.
    push_frame(8'hFF, 24'hFFFFFF, 1'b0);
    push_frame(8'h00, 24'h000000, 1'b0);
    push_frame(8'h80, 24'hAAAAAA, 1'b0);
    push_frame(8'h00, 24'h555555, 1'b0);
    push_frame(8'hFF, 24'h123456, 1'b0);
    push_frame(8'h01, 24'hFEDCBA, 1'b0);
    push_frame(8'h7F, 24'h800001, 1'b0);
    push_frame(8'h80, 24'h7FFFFE, 1'b0);
    push_frame(8'h55, 24'h0F0F0F, 1'b0);
    push_frame(8'hAA, 24'hF0F0F0, 1'b1);

    // A fully reversed batch, the order of its frames flips end to end.
    push_frame(8'd200, 24'h000001, 1'b0);
    push_frame(8'd150, 24'h000002, 1'b0);
    push_frame(8'd100, 24'h000003, 1'b0);
    push_frame(8'd50,  24'h000004, 1'b0);
    push_frame(8'd0,   24'h000005, 1'b1);

    // Let the whole directed part come back before anything else goes in.
    drain_results();

    // Capacity corners: a batch that exactly fills the store, one whose batch
    // end frame is the first to be dropped, and one that drops several.
    run_batch(frs_pkg::MAX_FRAMES);
    run_batch(frs_pkg::MAX_FRAMES + 1);
    drain_results();
    run_batch(frs_pkg::MAX_FRAMES + 5);

    // Random batches, mostly small. Now and then a large or oversized batch,
    // and now and then a full drain before the next one.
    while (frames_sent < 270) begin
      pick = $urandom_range(19, 0);
      if (pick == 0)
        run_batch($urandom_range(frs_pkg::MAX_FRAMES + 8, frs_pkg::MAX_FRAMES + 1));
      else if (pick == 1)
        run_batch($urandom_range(frs_pkg::MAX_FRAMES, frs_pkg::MAX_FRAMES - 4));
      else
        run_batch($urandom_range(12, 1));
      if ($urandom_range(7, 0) == 0)
        drain_results();
    end

    idle_cycles(1);
    while (sb.pending() != 0) @(posedge clk);
    // A stray beat after the last expected one would show up in this window.
    repeat (3 * frs_pkg::MAX_FRAMES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_500_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
